@@ design/utf8_to_utf16_decoder_core_macros.svh @@
// Assertion macros used by the decoder RTL.
`ifndef UTF8_TO_UTF16_DECODER_CORE_MACROS_SVH
`define UTF8_TO_UTF16_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define U8U16_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication failed");
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define U8U16_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ design/u8u16_pkg.sv @@
// Shared types, constants and helpers for the UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps
`default_nettype none
package u8u16_pkg;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [1:0] CLS_NONE  = 2'd0;
    localparam logic [1:0] CLS_TWO   = 2'd1;
    localparam logic [1:0] CLS_THREE = 2'd2;
    localparam logic [1:0] CLS_FOUR  = 2'd3;

    localparam logic [7:0]  LEAD2_LO   = 8'hc2;
    localparam logic [7:0]  LEAD2_HI   = 8'hdf;
    localparam logic [7:0]  LEAD3_LO   = 8'he0;
    localparam logic [7:0]  LEAD3_HI   = 8'hef;
    localparam logic [7:0]  LEAD4_LO   = 8'hf0;
    localparam logic [7:0]  LEAD4_HI   = 8'hf4;
    localparam logic [7:0]  CONT_MASK  = 8'hc0;
    localparam logic [7:0]  CONT_TAG   = 8'h80;
    localparam logic [20:0] MAX_CODE   = 21'h10ffff;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;
    localparam logic [20:0] SURR_LO    = 21'h00d800;
    localparam logic [20:0] SURR_HI    = 21'h00dfff;
    localparam logic [15:0] HI_SURR    = 16'hd800;
    localparam logic [15:0] LO_SURR    = 16'hdc00;
    localparam logic [9:0]  TEN_MASK   = 10'h3ff;

    typedef struct packed {
        logic        err;
        logic        pair;
        logic        eos;
        logic [15:0] unit0;
        logic [15:0] unit1;
    } t_item;

    function automatic logic [20:0] class_min(input logic [1:0] cls);
        logic [20:0] m;
        case (cls)
            CLS_TWO:   m = 21'h80;
            CLS_THREE: m = 21'h800;
            CLS_FOUR:  m = 21'h10000;
            default:   m = 21'h0;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

@@ design/utf8_to_utf16_decoder_core.sv @@
// Top level of the strict UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_to_utf16_decoder_core_macros.svh"
// Takes one UTF-8 byte per cycle whenever o_full is low and gives UTF-16
// code units through a four-entry queue; each byte is validated and decoded
// in the cycle it is taken. Code points above FFFF come out as a surrogate
// pair over two pops, so the result side sustains one unit per cycle while
// the queue is not empty and i_pop is high. The first invalid byte yields
// one error result (unit 0); further units are dropped until the byte
// marked last, which always produces a result carrying the end mark. State
// returns to its reset value after the last byte.
module utf8_to_utf16_decoder_core
    import u8u16_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_last_byte,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [15:0]      o_code_unit,
    output logic             o_error,
    output logic             o_end_of_stream
);

    logic  req;
    logic  item_valid;
    t_item item_in, item_out;
    logic  deq;
    logic  out_err;
    logic  out_hi;
    logic  out_lo;

    assign req = i_push && !o_full;

    u8u16_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .i_byte       (i_in_byte),
        .i_last       (i_last_byte),
        .o_item_valid (item_valid),
        .o_item       (item_in)
    );

    u8u16_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (req && item_valid),
        .i_item  (item_in),
        .i_pop   (deq),
        .o_item  (item_out),
        .o_full  (o_full),
        .o_empty (o_empty)
    );

    u8u16_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (item_out),
        .i_empty         (o_empty),
        .i_pop           (i_pop),
        .o_deq           (deq),
        .o_code_unit     (o_code_unit),
        .o_error         (o_error),
        .o_end_of_stream (o_end_of_stream)
    );

    assign out_err = !o_empty && o_error;
    assign out_hi  = !o_empty && !o_error && (o_code_unit[15:10] == 6'b110110);
    assign out_lo  = !o_empty && !o_error && (o_code_unit[15:10] == 6'b110111);

    `U8U16_ASSERT_IMPLY(a_err_unit_zero, i_clk, i_rst_n, out_err, o_code_unit == 16'd0)
    `U8U16_ASSERT_IMPLY(a_full_not_empty, i_clk, i_rst_n, o_full, !o_empty)
    `U8U16_ASSERT_IMPLY(a_hi_no_eos, i_clk, i_rst_n, out_hi, !o_end_of_stream)
    `U8U16_ASSERT_NEXT(a_hi_then_lo, i_clk, i_rst_n, out_hi && i_pop, out_lo)

endmodule
`default_nettype wire

@@ design/u8u16_front.sv @@
// Front end: validates bytes, gathers sequences and forms queue entries.
`timescale 1ns / 1ps
`default_nettype none
module u8u16_front
    import u8u16_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_last,
    output logic             o_item_valid,
    output t_item            o_item
);

    logic [1:0]  r_pending, n_pending;
    logic [20:0] r_partial, n_partial;
    logic [1:0]  r_min_class, n_min_class;
    logic        r_err_seen, n_err_seen;

    logic        bad;
    logic        have;
    logic [20:0] value;
    logic [20:0] shifted;
    logic [19:0] supp;

    assign shifted = {r_partial[14:0], i_byte[5:0]};

    always_comb begin
        n_pending   = r_pending;
        n_partial   = r_partial;
        n_min_class = r_min_class;
        n_err_seen  = r_err_seen;
        bad         = 1'b0;
        have        = 1'b0;
        value       = '0;
        o_item_valid = 1'b0;
        o_item       = '0;

        if (r_err_seen) begin
            if (i_last) begin
                o_item_valid = 1'b1;
                o_item.err   = 1'b1;
                o_item.eos   = 1'b1;
            end
        end else begin
            if (r_pending == 2'd0) begin
                if (!i_byte[7]) begin
                    value = {13'd0, i_byte};
                    have  = 1'b1;
                end else if (i_byte inside {[LEAD2_LO:LEAD2_HI]}) begin
                    n_partial   = {16'd0, i_byte[4:0]};
                    n_pending   = 2'd1;
                    n_min_class = CLS_TWO;
                end else if (i_byte inside {[LEAD3_LO:LEAD3_HI]}) begin
                    n_partial   = {17'd0, i_byte[3:0]};
                    n_pending   = 2'd2;
                    n_min_class = CLS_THREE;
                end else if (i_byte inside {[LEAD4_LO:LEAD4_HI]}) begin
                    n_partial   = {18'd0, i_byte[2:0]};
                    n_pending   = 2'd3;
                    n_min_class = CLS_FOUR;
                end else begin
                    bad = 1'b1;
                end
            end else if ((i_byte & CONT_MASK) != CONT_TAG) begin
                bad = 1'b1;
            end else begin
                n_partial = shifted;
                n_pending = r_pending - 2'd1;
                if (r_pending == 2'd1) begin
                    value = shifted;
                    if (shifted < class_min(r_min_class) || shifted > MAX_CODE ||
                        (shifted >= SURR_LO && shifted <= SURR_HI)) begin
                        bad = 1'b1;
                    end else begin
                        have = 1'b1;
                    end
                    n_partial   = '0;
                    n_min_class = CLS_NONE;
                end
            end

            if (!bad && i_last && n_pending != 2'd0) begin
                bad = 1'b1;
            end

            if (bad) begin
                o_item_valid = 1'b1;
                o_item.err   = 1'b1;
                o_item.eos   = i_last;
                n_err_seen   = 1'b1;
                n_pending    = 2'd0;
                n_partial    = '0;
                n_min_class  = CLS_NONE;
            end else if (have) begin
                o_item_valid = 1'b1;
                o_item.eos   = i_last;
                if (value >= SUPP_BASE) begin
                    o_item.pair  = 1'b1;
                    o_item.unit0 = HI_SURR | {6'd0, supp[19:10]};
                    o_item.unit1 = LO_SURR | {6'd0, supp[9:0] & TEN_MASK};
                end else begin
                    o_item.unit0 = value[15:0];
                end
            end
        end

        if (i_last) begin
            n_pending   = 2'd0;
            n_partial   = '0;
            n_min_class = CLS_NONE;
            n_err_seen  = 1'b0;
        end
    end

    assign supp = 20'(value - SUPP_BASE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= 2'd0;
            r_partial   <= '0;
            r_min_class <= CLS_NONE;
            r_err_seen  <= 1'b0;
        end else if (i_req) begin
            r_pending   <= n_pending;
            r_partial   <= n_partial;
            r_min_class <= n_min_class;
            r_err_seen  <= n_err_seen;
        end
    end

endmodule
`default_nettype wire

@@ design/u8u16_queue.sv @@
// Short queue of decoded entries between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module u8u16_queue
    import u8u16_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_item  i_item,
    input  wire logic   i_pop,
    output t_item       o_item,
    output logic        o_full,
    output logic        o_empty
);

    t_item              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr, r_rptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ design/u8u16_back.sv @@
// Back end: presents queue entries as code units, splitting surrogate pairs.
`timescale 1ns / 1ps
`default_nettype none
module u8u16_back
    import u8u16_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_item        i_item,
    input  wire logic         i_empty,
    input  wire logic         i_pop,
    output logic              o_deq,
    output logic [15:0]       o_code_unit,
    output logic              o_error,
    output logic              o_end_of_stream
);

    logic r_phase, n_phase;
    logic take;

    assign take  = i_pop && !i_empty;
    assign o_deq = take && (!i_item.pair || r_phase);

    assign o_code_unit     = r_phase ? i_item.unit1 : i_item.unit0;
    assign o_error         = i_item.err;
    assign o_end_of_stream = i_item.eos && (!i_item.pair || r_phase);

    always_comb begin
        n_phase = r_phase;
        if (take) begin
            n_phase = i_item.pair && !r_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else begin
            r_phase <= n_phase;
        end
    end

endmodule
`default_nettype wire
